@@ sv/isc_pkg.sv @@
// Shared types and constants for the itemset support counter.
`timescale 1ns / 1ps
package isc_pkg;

  localparam int MAX_TRANSACTIONS = 1024;
  localparam int ITEM_BITS        = 64;
  localparam int ADDR_W           = $clog2(MAX_TRANSACTIONS);
  localparam int COUNT_W          = $clog2(MAX_TRANSACTIONS + 1);
  localparam int FIELD_COUNT_W    = 11;
  localparam int THR_W            = 17;
  localparam int FRAC_W           = 16;
  localparam int PROD_W           = THR_W + COUNT_W;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONFIDENCE = 2'd1;

  localparam logic [THR_W-1:0] MIN_SUPPORT_RST    = 17'd32768;
  localparam logic [THR_W-1:0] MIN_CONFIDENCE_RST = 17'd45875;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_SUPPORT = 2'd2,
    ACT_RULE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_CMP
  } back_state_t;

  // input word
  typedef struct packed {
    action_t     action;
    logic [63:0] itemset_a;
    logic [63:0] itemset_b;
  } cmd_t;

  // result word
  typedef struct packed {
    status_t                  status;
    logic [FIELD_COUNT_W-1:0] joint_count;
    logic [FIELD_COUNT_W-1:0] antecedent_count;
    logic                     passes;
  } result_t;

  // classified command held in the queue between front and back
  typedef struct packed {
    action_t              action;
    logic                 is_query;
    logic [ITEM_BITS-1:0] a;
    logic [ITEM_BITS-1:0] both;
  } op_t;

endpackage

@@ sv/itemset_support_counter.sv @@
// Top level of the itemset support counter: front, back and threshold registers.
`timescale 1ns / 1ps
// Itemset support counter over a store of up to MAX_TRANSACTIONS item bitmaps.
// Command channel: a word (cmd) is taken at a clock edge with start high and
// busy low. A two-deep queue sits between the front end and the back end, so
// busy rises only when two words wait behind the one being worked on.
// Actions: clear the store, append a transaction, support query, rule query.
// Result channel: one result word per command, shown on result for exactly one
// cycle with done high. The receiver cannot stall; it must take it then.
// Work per word in the back end: clear, append, and any query on an empty
// store finish without a scan. A query scans the stored transactions through the
// store's single read port, one entry per cycle, then waits out the read
// latency, multiplies and compares. Result appears in the cycle after the back
// end finishes the word.
// Config channel: cfg_valid/cfg_ready write min_support (index 0) or
// min_confidence (index 1), both Q1.16; cfg_ready is always high. Write only
// while no command is pending.
// Reset (rst, synchronous): store empty, queue empty, thresholds to 0.5 and
// about 0.7. Store contents are not cleared; only entries below the count are read.
module itemset_support_counter import isc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cmd_t                 cmd,
  output logic                 busy,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  logic             q_valid;
  logic             q_pop;
  op_t              q_word;
  logic [THR_W-1:0] min_support;
  logic [THR_W-1:0] min_confidence;

  assign cfg_ready = 1'b1;

  // threshold registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      min_support    <= MIN_SUPPORT_RST;
      min_confidence <= MIN_CONFIDENCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_SUPPORT) begin
        min_support <= cfg_data;
      end
      if (cfg_index == CFG_MIN_CONFIDENCE) begin
        min_confidence <= cfg_data;
      end
    end
  end

  isc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .q_valid(q_valid),
    .q_word (q_word),
    .q_pop  (q_pop)
  );

  isc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop),
    .min_support   (min_support),
    .min_confidence(min_confidence),
    .done          (done),
    .result        (result)
  );

endmodule

@@ sv/isc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module isc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/isc_front.sv @@
// Command front end: accepts words, classifies them, queues them for the back end.
`timescale 1ns / 1ps
module isc_front import isc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic q_valid,
  output op_t  q_word,
  input  logic q_pop
);

  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  op_t        slots [2];
  op_t        op_in;

  // classify and trim to the item width
  always_comb begin
    op_in.action   = cmd.action;
    op_in.is_query = (cmd.action == ACT_SUPPORT) || (cmd.action == ACT_RULE);
    op_in.a        = cmd.itemset_a[ITEM_BITS-1:0];
    op_in.both     = cmd.itemset_a[ITEM_BITS-1:0] | cmd.itemset_b[ITEM_BITS-1:0];
  end

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_word  = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !q_pop) begin
      fill_next = fill + 2'd1;
    end else if (q_pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  pop_needs_word: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

@@ sv/isc_back.sv @@
// Back end: store updates, transaction scan, threshold test, result register.
`timescale 1ns / 1ps
module isc_back import isc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  op_t              q_word,
  output logic             q_pop,
  input  logic [THR_W-1:0] min_support,
  input  logic [THR_W-1:0] min_confidence,
  output logic             done,
  output result_t          result
);

  back_state_t          state;
  back_state_t          state_next;
  logic [COUNT_W-1:0]   stored_count;
  logic [COUNT_W-1:0]   rd_addr;
  logic                 pend;
  logic [COUNT_W-1:0]   cnt_ante;
  logic [COUNT_W-1:0]   cnt_joint;
  op_t                  cur;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    lhs;
  logic [ITEM_BITS-1:0] rd_word;
  logic                 issue;
  logic                 ram_we;
  logic                 store_full;
  logic                 fast_done;
  logic                 hit_a;
  logic                 hit_both;
  logic                 pass_now;
  result_t              fast_res;

  assign store_full = (stored_count >= COUNT_W'(MAX_TRANSACTIONS));

  // output decode
  always_comb begin
    q_pop     = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    fast_done = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop     = q_valid;
        ram_we    = q_valid && (q_word.action == ACT_APPEND) && !store_full;
        fast_done = q_valid && (!q_word.is_query || (stored_count == '0));
      end
      BK_SCAN: begin
        issue = (rd_addr < stored_count);
      end
      BK_MUL, BK_CMP: begin
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_word.is_query && (stored_count != '0)) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (!issue && !pend) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL:  state_next = BK_CMP;
      BK_CMP:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // result for words finished without a scan
  always_comb begin
    fast_res                  = '0;
    fast_res.status           = ST_OK;
    if (q_word.action == ACT_APPEND && store_full) begin
      fast_res.status = ST_FULL;
    end else if (q_word.is_query) begin
      fast_res.status = ST_EMPTY;
    end
  end

  assign hit_a    = ((rd_word & cur.a) == cur.a);
  assign hit_both = ((rd_word & cur.both) == cur.both);

  assign lhs = PROD_W'({cnt_joint, {FRAC_W{1'b0}}});
  always_comb begin
    if (cur.action == ACT_RULE) begin
      pass_now = (cnt_ante != '0) && (lhs > prod);
    end else begin
      pass_now = (lhs >= prod);
    end
  end

  isc_ram #(
    .WIDTH(ITEM_BITS),
    .DEPTH(MAX_TRANSACTIONS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(stored_count[ADDR_W-1:0]),
    .wdata(q_word.a),
    .re   (issue),
    .raddr(rd_addr[ADDR_W-1:0]),
    .rdata(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      stored_count <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      done  <= fast_done || (state == BK_CMP);
      if (q_pop && q_word.action == ACT_CLEAR) begin
        stored_count <= '0;
      end else if (ram_we) begin
        stored_count <= stored_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_word;
      rd_addr   <= '0;
      cnt_ante  <= '0;
      cnt_joint <= '0;
    end
    if (issue) begin
      rd_addr <= rd_addr + COUNT_W'(1);
    end
    if (pend) begin
      if (hit_a) begin
        cnt_ante <= cnt_ante + COUNT_W'(1);
      end
      // a support query counts the itemset itself as the joint count
      if ((cur.action == ACT_RULE) ? hit_both : hit_a) begin
        cnt_joint <= cnt_joint + COUNT_W'(1);
      end
    end
    if (state == BK_MUL) begin
      if (cur.action == ACT_RULE) begin
        prod <= PROD_W'(min_confidence * cnt_ante);
      end else begin
        prod <= PROD_W'(min_support * stored_count);
      end
    end
    if (fast_done) begin
      result <= fast_res;
    end else if (state == BK_CMP) begin
      result.status           <= ST_OK;
      result.joint_count      <= FIELD_COUNT_W'(cnt_joint);
      result.antecedent_count <= (cur.action == ACT_RULE) ? FIELD_COUNT_W'(cnt_ante) : '0;
      result.passes           <= pass_now;
    end
  end

  scan_in_range: assert property (@(posedge clk) disable iff (rst)
      (state == BK_SCAN) |-> (rd_addr <= stored_count))
    else $error("scan address ran past the stored count");

  count_bounded: assert property (@(posedge clk) disable iff (rst)
      stored_count <= COUNT_W'(MAX_TRANSACTIONS))
    else $error("stored count above capacity");

  cmp_then_done: assert property (@(posedge clk) disable iff (rst)
      (state == BK_CMP) |=> done)
    else $error("finished query gave no result");

  error_clean: assert property (@(posedge clk) disable iff (rst)
      (done && result.status != ST_OK) |->
      (result.joint_count == '0 && result.antecedent_count == '0 && !result.passes))
    else $error("error result carries counts");

  no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
      issue |-> !ram_we && !q_pop)
    else $error("store written during a scan");

endmodule
